// ===== src/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;
    localparam logic [2:0] OP_SPLIT = 3'd5;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic signed [31:0] whole_part;
        logic               is_less;
        logic               is_equal;
        logic               is_greater;
        logic [1:0]         error_code;
    } rsp_t;

endpackage

// ===== src/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_stall   | rau_pkg::req_t
// out     | output    | out_valid/out_stall | rau_pkg::rsp_t
// One request at a time. A zero denominator is answered straight from S_LOAD. The shared
// 64-bit restoring divider runs every Euclidean GCD step, both divides by the GCD and the
// split division; a 32x32 multiplier forms the products. Reset clears the sequencer and
// the output valid. in_stall is high from acceptance until the result has been handed
// over; the result holds while out_stall is high.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rau_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output rau_pkg::rsp_t out_data
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RED_A, S_RED_B, S_CHK, S_M1, S_M2, S_M3, S_COMB,
        S_SPLIT, S_SPLIT_W, S_FIN, S_GCD, S_DIV, S_GDONE, S_OUT
    } state_t;

    state_t state_reg;
    state_t ret_reg;
    logic [2:0] op_reg;
    logic an_reg, bn_reg, rn_reg;
    logic [63:0] am_reg, ad_reg, bm_reg, bd_reg, rm_reg, rd_reg;
    logic [63:0] p_reg, q_reg;
    logic [63:0] gx_reg, gy_reg;
    logic [63:0] dq_reg, drem_reg, ddiv_reg, dnum_reg;
    logic [6:0] cnt_reg;
    logic [1:0] red_sel_reg;
    logic [1:0] mstep_reg;
    logic [31:0] whole_reg;
    logic lt_reg, eq_reg, gt_reg;
    logic [1:0] err_reg;
    logic out_valid_reg;

    logic [W-1:0] an_w, ad_w, bn_w, bd_w;
    logic [W-1:0] anm, adm, bnm, bdm;
    assign an_w = in_data.a_num[W-1:0];
    assign ad_w = in_data.a_den[W-1:0];
    assign bn_w = in_data.b_num[W-1:0];
    assign bd_w = in_data.b_den[W-1:0];
    assign anm = an_w[W-1] ? (~an_w + W'(1)) : an_w;
    assign adm = ad_w[W-1] ? (~ad_w + W'(1)) : ad_w;
    assign bnm = bn_w[W-1] ? (~bn_w + W'(1)) : bn_w;
    assign bdm = bd_w[W-1] ? (~bd_w + W'(1)) : bd_w;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    logic [64:0] trial;
    assign trial = {drem_reg, dnum_reg[63]} - {1'b0, ddiv_reg};

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        mul_a = ad_reg[31:0];
        mul_b = bd_reg[31:0];
        unique case (mstep_reg)
            2'd0:
            begin
                mul_a = am_reg[31:0];
                mul_b = (op_reg == OP_MUL) ? bm_reg[31:0] : bd_reg[31:0];
            end
            2'd1:
            begin
                mul_a = (op_reg == OP_MUL || op_reg == OP_DIV) ? ad_reg[31:0]
                                                               : bm_reg[31:0];
                mul_b = (op_reg == OP_DIV) ? bm_reg[31:0]
                      : ((op_reg == OP_MUL) ? bd_reg[31:0] : ad_reg[31:0]);
            end
            default:
            begin
                mul_a = ad_reg[31:0];
                mul_b = bd_reg[31:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            ret_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= in_data.op;
                        an_reg <= (anm != '0) && (an_w[W-1] != ad_w[W-1]);
                        bn_reg <= (bnm != '0) && (bn_w[W-1] != bd_w[W-1]);
                        am_reg <= 64'(anm);
                        ad_reg <= 64'(adm);
                        bm_reg <= 64'(bnm);
                        bd_reg <= 64'(bdm);
                        whole_reg <= '0;
                        lt_reg <= 1'b0;
                        eq_reg <= 1'b0;
                        gt_reg <= 1'b0;
                        err_reg <= ERR_OK;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (ad_reg == 64'd0 || (op_reg <= OP_CMP && bd_reg == 64'd0))
                    begin
                        err_reg <= ERR_ZERO_DEN;
                        state_reg <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        red_sel_reg <= 2'd0;
                        rn_reg <= an_reg;
                        rm_reg <= am_reg;
                        rd_reg <= ad_reg;
                        ret_reg <= S_RED_A;
                        state_reg <= S_GCD;
                        gx_reg <= am_reg;
                        gy_reg <= ad_reg;
                    end
                end
                S_RED_A:
                begin
                    an_reg <= rn_reg;
                    am_reg <= rm_reg;
                    ad_reg <= rd_reg;
                    rn_reg <= bn_reg;
                    rm_reg <= bm_reg;
                    rd_reg <= bd_reg;
                    gx_reg <= bm_reg;
                    gy_reg <= bd_reg;
                    ret_reg <= S_RED_B;
                    state_reg <= (op_reg <= OP_CMP) ? S_GCD : S_CHK;
                end
                S_RED_B:
                begin
                    bn_reg <= rn_reg;
                    bm_reg <= rm_reg;
                    bd_reg <= rd_reg;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    mstep_reg <= 2'd0;
                    if (op_reg == OP_SUB && bm_reg != 64'd0)
                        bn_reg <= ~bn_reg;
                    if (op_reg == OP_DIV && bm_reg == 64'd0)
                    begin
                        err_reg <= ERR_DIV_ZERO;
                        state_reg <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else if (op_reg == OP_SPLIT)
                    begin
                        dnum_reg <= am_reg;
                        ddiv_reg <= ad_reg;
                        drem_reg <= '0;
                        dq_reg <= '0;
                        cnt_reg <= 7'd64;
                        ret_reg <= S_SPLIT_W;
                        state_reg <= S_DIV;
                    end
                    else if (op_reg > OP_SPLIT)
                    begin
                        rn_reg <= an_reg;
                        rm_reg <= am_reg;
                        rd_reg <= ad_reg;
                        state_reg <= S_FIN;
                    end
                    else
                        state_reg <= S_M1;
                end
                S_M1:
                begin
                    p_reg <= mul_p;
                    mstep_reg <= 2'd1;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    q_reg <= mul_p;
                    mstep_reg <= 2'd2;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    rd_reg <= mul_p;
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    unique case (op_reg)
                        OP_MUL:
                        begin
                            rn_reg <= an_reg != bn_reg;
                            rm_reg <= p_reg;
                            rd_reg <= q_reg;
                        end
                        OP_DIV:
                        begin
                            rn_reg <= an_reg != bn_reg;
                            rm_reg <= p_reg;
                            rd_reg <= q_reg;
                        end
                        OP_CMP:
                        begin
                            if (an_reg != bn_reg)
                            begin
                                lt_reg <= an_reg;
                                gt_reg <= bn_reg;
                            end
                            else
                            begin
                                eq_reg <= p_reg == q_reg;
                                lt_reg <= an_reg ? (p_reg > q_reg) : (p_reg < q_reg);
                                gt_reg <= an_reg ? (p_reg < q_reg) : (p_reg > q_reg);
                            end
                            rn_reg <= 1'b0;
                            rm_reg <= '0;
                            rd_reg <= 64'd1;
                        end
                        default:
                        begin
                            if (an_reg == bn_reg)
                            begin
                                rm_reg <= p_reg + q_reg;
                                rn_reg <= an_reg;
                            end
                            else if (p_reg >= q_reg)
                            begin
                                rm_reg <= p_reg - q_reg;
                                rn_reg <= an_reg;
                            end
                            else
                            begin
                                rm_reg <= q_reg - p_reg;
                                rn_reg <= bn_reg;
                            end
                        end
                    endcase
                    state_reg <= S_FIN;
                    if (op_reg <= OP_DIV)
                        state_reg <= S_SPLIT;
                end
                S_SPLIT:
                begin
                    gx_reg <= rm_reg;
                    gy_reg <= rd_reg;
                    ret_reg <= S_FIN;
                    state_reg <= S_GCD;
                end
                S_SPLIT_W:
                begin
                    if (an_reg)
                        whole_reg <= (dq_reg > 64'h8000_0000) ? 32'h8000_0000
                                   : (~dq_reg[31:0] + 32'd1);
                    else
                        whole_reg <= (dq_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dq_reg[31:0];
                    rn_reg <= an_reg;
                    rm_reg <= drem_reg;
                    rd_reg <= ad_reg;
                    gx_reg <= drem_reg;
                    gy_reg <= ad_reg;
                    ret_reg <= S_FIN;
                    state_reg <= S_GCD;
                end
                S_GCD:
                begin
                    if (rm_reg == 64'd0)
                    begin
                        rn_reg <= 1'b0;
                        rd_reg <= 64'd1;
                        state_reg <= ret_reg;
                    end
                    else if (gy_reg == 64'd0)
                    begin
                        red_sel_reg <= 2'd1;
                        dnum_reg <= rm_reg;
                        ddiv_reg <= gx_reg;
                        drem_reg <= '0;
                        dq_reg <= '0;
                        cnt_reg <= 7'd64;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        red_sel_reg <= 2'd0;
                        dnum_reg <= gx_reg;
                        ddiv_reg <= gy_reg;
                        drem_reg <= '0;
                        dq_reg <= '0;
                        cnt_reg <= 7'd64;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 7'd0)
                        state_reg <= S_GDONE;
                    else
                    begin
                        if (!trial[64])
                        begin
                            drem_reg <= trial[63:0];
                            dq_reg <= {dq_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= {drem_reg[62:0], dnum_reg[63]};
                            dq_reg <= {dq_reg[62:0], 1'b0};
                        end
                        dnum_reg <= {dnum_reg[62:0], 1'b0};
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_GDONE:
                begin
                    if (ret_reg == S_SPLIT_W)
                        state_reg <= S_SPLIT_W;
                    else if (red_sel_reg == 2'd0)
                    begin
                        gx_reg <= gy_reg;
                        gy_reg <= drem_reg;
                        state_reg <= S_GCD;
                    end
                    else if (red_sel_reg == 2'd1)
                    begin
                        rm_reg <= dq_reg;
                        red_sel_reg <= 2'd2;
                        dnum_reg <= rd_reg;
                        ddiv_reg <= gx_reg;
                        drem_reg <= '0;
                        dq_reg <= '0;
                        cnt_reg <= 7'd64;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        rd_reg <= dq_reg;
                        state_reg <= ret_reg;
                    end
                end
                S_FIN:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic [63:0] mag_sat;
    assign mag_sat = rm_reg[63] ? 64'h7FFF_FFFF_FFFF_FFFF : rm_reg;

    always_comb
    begin
        out_data = '0;
        out_data.error_code = err_reg;
        if (err_reg == ERR_OK)
        begin
            out_data.res_num = rn_reg ? (~mag_sat + 64'd1) : mag_sat;
            out_data.res_den = rd_reg[62:0];
            out_data.whole_part = whole_reg;
            out_data.is_less = lt_reg;
            out_data.is_equal = eq_reg;
            out_data.is_greater = gt_reg;
        end
    end

endmodule
